// ===== src/log_log_table_interpolator_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LOG_LOG_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH
`define LOG_LOG_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LLI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lli port assertion failed");

// Consequent checked in the cycle after the antecedent.
`define LLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lli port assertion failed");

`endif

// ===== src/lli_pkg.sv =====
package lli_pkg;

    localparam int VALUE_BITS = 32;
    localparam int LOG_W      = 24;
    localparam int DIV_W      = 48;
    localparam int DSR_W      = 23;
    localparam int R_W        = 50;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]            operation;
        logic [VALUE_BITS-1:0] x_value;
        logic [VALUE_BITS-1:0] y_value;
    } lli_in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] interpolated_y;
        logic                  out_of_range;
    } lli_out_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] x;
        logic [VALUE_BITS-1:0] y;
    } point_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_LAST_READ,
        S_LAST_CMP,
        S_LOG_INIT,
        S_LOG_SQ,
        S_MUL,
        S_DIV,
        S_EXP_INIT,
        S_EXP_MUL,
        S_EXP_SHIFT,
        S_OUT
    } state_t;

    function automatic logic [63:0] isqrt64(logic [63:0] a);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = a;
        for (int i = 0; i < 32; i++)
        begin
            if (b > rem)
            begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (rem >= r + b)
                begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q1.31 factor for 2^(2^-k)
    function automatic logic [31:0] exp_coef(int k);
        logic [63:0] c;
        c = 64'd1 << 32;
        for (int j = 1; j <= 16; j++)
        begin
            if (j <= k)
            begin
                c = isqrt64(c << 31);
            end
        end
        return c[31:0];
    endfunction

    localparam logic [31:0] EXP_COEF [16] = '{
        exp_coef(1),  exp_coef(2),  exp_coef(3),  exp_coef(4),
        exp_coef(5),  exp_coef(6),  exp_coef(7),  exp_coef(8),
        exp_coef(9),  exp_coef(10), exp_coef(11), exp_coef(12),
        exp_coef(13), exp_coef(14), exp_coef(15), exp_coef(16)
    };

endpackage

// ===== src/lli_point_mem.sv =====
module lli_point_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  lli_pkg::point_t  wr_point,
    input  logic [AW-1:0]    rd_addr,
    output lli_pkg::point_t  rd_point
);
    import lli_pkg::*;

    point_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_point;
        end
        rd_point <= mem[rd_addr];
    end

endmodule

// ===== src/log_log_table_interpolator_unit.sv =====
// Append and clear are done in the idle state. A query reads and compares table
// entries one at a time, then takes five logarithms, one product, a division
// (skipped when both abscissas have equal logs) and an exp2, the logs, product and
// exp2 sharing one 32x32 multiplier, and then loads the output register.
// Out-of-range answers skip the logarithm, division and exp2 steps.
// Reset is asynchronous, active low; it empties the table and drops any result.
module log_log_table_interpolator_unit #(
    parameter int MAX_POINTS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lli_pkg::lli_in_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output lli_pkg::lli_out_t out_item
);
    import lli_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic          out_valid_reg, out_valid_next;
    lli_out_t      out_item_reg, out_item_next;

    logic [VALUE_BITS-1:0] query_reg, query_next;
    point_t        lo_reg, lo_next, hi_reg, hi_next;
    logic [VALUE_BITS-1:0] res_y_reg, res_y_next;
    logic          res_flag_reg, res_flag_next;
    logic [31:0]   m_reg, m_next;
    logic [15:0]   frac_reg, frac_next;
    logic [4:0]    p_reg, p_next;
    logic [5:0]    step_reg, step_next;
    logic [2:0]    sel_reg, sel_next;
    logic signed [LOG_W-1:0] logs_reg [5];
    logic signed [LOG_W-1:0] logs_next [5];
    logic          sign_reg, sign_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W:0]   rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic signed [6:0] n_reg, n_next;

    point_t        rd_point;
    logic          mem_we;
    point_t        mem_wpt;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic          out_free;

    logic signed [LOG_W-1:0] dy, dq, dx;
    logic [LOG_W-1:0] dy_mag, dq_mag, dx_mag;
    logic [VALUE_BITS-1:0] log_src, log_v;
    logic [4:0]    log_p;
    logic [32:0]   sq;
    logic [5:0]    pm;
    logic [DSR_W:0] rem_sh;
    logic signed [R_W-1:0] q_s, r_val, e_val, n_wide;
    logic [6:0]    shamt;
    logic [63:0]   shifted;

    lli_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk      (clk),
        .wr_en    (mem_we),
        .wr_addr  (count_reg[AW-1:0]),
        .wr_point (mem_wpt),
        .rd_addr  (raddr_reg),
        .rd_point (rd_point)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign prod     = 64'(mul_a) * 64'(mul_b);

    assign dy = logs_reg[3] - logs_reg[2];
    assign dq = logs_reg[4] - logs_reg[0];
    assign dx = logs_reg[1] - logs_reg[0];
    assign dy_mag = dy[LOG_W-1] ? LOG_W'(-dy) : LOG_W'(dy);
    assign dq_mag = dq[LOG_W-1] ? LOG_W'(-dq) : LOG_W'(dq);
    assign dx_mag = dx[LOG_W-1] ? LOG_W'(-dx) : LOG_W'(dx);

    always_comb
    begin
        unique case (sel_reg)
            3'd0:    log_src = lo_reg.x;
            3'd1:    log_src = hi_reg.x;
            3'd2:    log_src = lo_reg.y;
            3'd3:    log_src = hi_reg.y;
            default: log_src = query_reg;
        endcase
        log_v = (log_src == '0) ? VALUE_BITS'(1) : log_src;
        log_p = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (log_v[i])
            begin
                log_p = 5'(i);
            end
        end
    end

    assign sq     = prod[63:31];
    assign pm     = {1'b0, p_reg} - 6'd16;
    assign rem_sh = {rem_reg[DSR_W-1:0], dvd_reg[DIV_W-1]};
    assign q_s    = sign_reg ? -R_W'($signed({1'b0, dvd_reg}))
                             : R_W'($signed({1'b0, dvd_reg}));
    assign r_val  = R_W'(logs_reg[2]) + q_s;
    assign e_val  = r_val + R_W'(32'sd1048576);
    assign n_wide = e_val >>> 16;
    assign shamt  = 7'd31 - 7'(n_reg);
    assign shifted = {32'd0, m_reg} >> shamt;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_item.operation == OP_QUERY)
                begin
                    state_next = (count_reg == '0) ? S_OUT : S_READ;
                end
            end
            S_READ:      state_next = S_CMP;
            S_CMP:
            begin
                if (rd_point.x > query_reg)
                begin
                    state_next = (idx_reg == '0) ? S_LAST_READ : S_LOG_INIT;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_LAST_READ: state_next = S_LAST_CMP;
            S_LAST_CMP:  state_next = S_OUT;
            S_LOG_INIT:  state_next = S_LOG_SQ;
            S_LOG_SQ:
            begin
                if (step_reg == 6'd15)
                begin
                    state_next = (sel_reg == 3'd4) ? S_MUL : S_LOG_INIT;
                end
            end
            S_MUL:       state_next = (dx == '0) ? S_EXP_INIT : S_DIV;
            S_DIV:
            begin
                if (step_reg == 6'(DIV_W - 1))
                begin
                    state_next = S_EXP_INIT;
                end
            end
            S_EXP_INIT:
            begin
                if (n_wide >= R_W'(32) || n_wide < -R_W'(33))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_EXP_MUL;
                end
            end
            S_EXP_MUL:
            begin
                if (step_reg == 6'd15)
                begin
                    state_next = S_EXP_SHIFT;
                end
            end
            S_EXP_SHIFT: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        mem_we   = (state_reg == S_IDLE) && in_valid && in_item.operation == OP_APPEND
                   && count_reg < CW'(MAX_POINTS);
        mem_wpt  = '{x: in_item.x_value, y: in_item.y_value};
        unique case (state_reg)
            S_LOG_SQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_MUL:
            begin
                mul_a = 32'(dy_mag);
                mul_b = 32'(dq_mag);
            end
            S_EXP_MUL:
            begin
                mul_a = m_reg;
                mul_b = EXP_COEF[step_reg[3:0]];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        raddr_next     = raddr_reg;
        query_next     = query_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_y_next     = res_y_reg;
        res_flag_next  = res_flag_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        p_next         = p_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        logs_next      = logs_reg;
        sign_next      = sign_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        n_next         = n_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority case (in_item.operation)
                        OP_APPEND:
                        begin
                            if (count_reg < CW'(MAX_POINTS))
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_CLEAR: count_next = '0;
                        OP_QUERY:
                        begin
                            query_next    = in_item.x_value;
                            idx_next      = '0;
                            raddr_next    = '0;
                            res_y_next    = '0;
                            res_flag_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_CMP:
            begin
                if (rd_point.x > query_reg)
                begin
                    hi_next    = rd_point;
                    sel_next   = '0;
                    raddr_next = AW'(count_reg - CW'(1));
                end
                else
                begin
                    lo_next    = rd_point;
                    res_y_next = rd_point.y;
                    idx_next   = idx_reg + CW'(1);
                    raddr_next = AW'(idx_reg + CW'(1));
                end
            end
            S_LAST_CMP: res_y_next = rd_point.y;
            S_LOG_INIT:
            begin
                p_next    = log_p;
                m_next    = log_v << (5'd31 - log_p);
                frac_next = '0;
                step_next = '0;
            end
            S_LOG_SQ:
            begin
                frac_next = {frac_reg[14:0], sq[32]};
                m_next    = sq[32] ? sq[32:1] : sq[31:0];
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd15)
                begin
                    logs_next[sel_reg] = {{(LOG_W-22){pm[5]}}, pm, frac_reg[14:0], sq[32]};
                    sel_next = sel_reg + 3'd1;
                end
            end
            S_MUL:
            begin
                step_next = '0;
                rem_next  = '0;
                dsr_next  = dx_mag[DSR_W-1:0];
                if (dx == '0)
                begin
                    dvd_next  = '0;
                    sign_next = 1'b0;
                end
                else
                begin
                    dvd_next  = prod[DIV_W-1:0];
                    sign_next = dy[LOG_W-1] ^ dq[LOG_W-1] ^ dx[LOG_W-1];
                end
            end
            S_DIV:
            begin
                step_next = step_reg + 6'd1;
                if (rem_sh >= {1'b0, dsr_reg})
                begin
                    rem_next = rem_sh - {1'b0, dsr_reg};
                    dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                end
            end
            S_EXP_INIT:
            begin
                res_flag_next = 1'b0;
                n_next        = n_wide[6:0];
                frac_next     = e_val[15:0];
                m_next        = 32'h8000_0000;
                step_next     = '0;
                if (n_wide >= R_W'(32))
                begin
                    res_y_next = '1;
                end
                else
                begin
                    res_y_next = '0;
                end
            end
            S_EXP_MUL:
            begin
                step_next = step_reg + 6'd1;
                if (frac_reg[4'd15 - step_reg[3:0]])
                begin
                    m_next = prod[62:31];
                end
            end
            S_EXP_SHIFT: res_y_next = shifted[VALUE_BITS-1:0];
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{interpolated_y: res_y_reg, out_of_range: res_flag_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
            sel_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg    <= raddr_next;
        query_reg    <= query_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_y_reg    <= res_y_next;
        res_flag_reg <= res_flag_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        p_reg        <= p_next;
        logs_reg     <= logs_next;
        sign_reg     <= sign_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        n_reg        <= n_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== src/lli_checker.sv =====
`include "log_log_table_interpolator_unit_defines.svh"

module lli_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input lli_pkg::lli_in_t  in_item,
    input logic              out_valid,
    input logic              out_ready,
    input lli_pkg::lli_out_t out_item
);
    import lli_pkg::*;

    // a pending result holds until taken
    `LLI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // a query transaction blocks the input for at least the next cycle
    `LLI_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_item.operation == OP_QUERY,
        !in_ready)

    // a new result is only loaded while the input side is held off
    `LLI_ASSERT_NOW(a_rise_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind log_log_table_interpolator_unit lli_checker u_lli_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import lli_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int WATCHDOG_MAX  = 20000;
    localparam longint LOG_UNIT  = 65536;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    lli_in_t  in_item;
    logic     out_valid;
    logic     out_ready;
    lli_out_t out_item;

    log_log_table_interpolator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // predictor state
    logic [31:0] tbl_x [TABLE_DEPTH];
    logic [31:0] tbl_y [TABLE_DEPTH];
    int          tbl_count;
    lli_out_t    expected_results[$];

    int  mismatches = 0;
    int  idle_max;
    int  hold_off_cycles = 0;
    int  quiet_cycles = 0;
    bit  timed_out = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned a);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint fx_log2(logic [31:0] v_in);
        longint unsigned v;
        longint unsigned m;
        longint          frac;
        int              p;
        v    = 64'(v_in);
        frac = 0;
        p    = 0;
        if (v == 0)
            v = 1;
        for (int i = 0; i < 64; i++)
            if (v[i])
                p = i;
        if (p >= 31)
            m = v >> (p - 31);
        else
            m = v << (31 - p);
        for (int i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32))
            begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        return longint'(p - 16) * LOG_UNIT + frac;
    endfunction

    function automatic logic [31:0] fx_exp2(longint r);
        longint unsigned coef [17];
        longint unsigned m;
        longint          e;
        longint          n;
        longint          f;
        m = 64'd1 << 31;
        e = r + 16 * LOG_UNIT;
        if (e >= 0)
            n = e / LOG_UNIT;
        else
            n = -((-e + (LOG_UNIT - 1)) / LOG_UNIT);
        f = e - n * LOG_UNIT;
        if (n >= 32)
            return 32'hFFFF_FFFF;
        if (n < -33)
            return 32'd0;
        coef[0] = 64'd1 << 32;
        for (int k = 1; k <= 16; k++)
            coef[k] = int_sqrt(coef[k-1] << 31);
        for (int k = 1; k <= 16; k++)
            if (f[16-k])
                m = (m * coef[k]) >> 31;
        if (n >= 31)
            m = m << (n - 31);
        else
            m = m >> (31 - n);
        return m[31:0];
    endfunction

    // advance the table copy; queue the answer a query produces
    function automatic void interp_model_step(lli_in_t it);
        lli_out_t res;
        int       upper;
        bit       found;
        longint   lx0, lx1, ly0, ly1, lq, dx, r;
        found = 0;
        upper = 0;
        case (it.operation)
            OP_APPEND:
            begin
                if (tbl_count < TABLE_DEPTH)
                begin
                    tbl_x[tbl_count] = it.x_value;
                    tbl_y[tbl_count] = it.y_value;
                    tbl_count++;
                end
            end
            OP_CLEAR:
                tbl_count = 0;
            OP_QUERY:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (!found && tbl_x[i] > it.x_value)
                    begin
                        upper = i;
                        found = 1;
                    end
                end
                if (!found || upper < 1)
                begin
                    res.interpolated_y = (tbl_count > 0) ? tbl_y[tbl_count-1] : 32'd0;
                    res.out_of_range   = 1'b1;
                end
                else
                begin
                    lx0 = fx_log2(tbl_x[upper-1]);
                    lx1 = fx_log2(tbl_x[upper]);
                    ly0 = fx_log2(tbl_y[upper-1]);
                    ly1 = fx_log2(tbl_y[upper]);
                    lq  = fx_log2(it.x_value);
                    dx  = lx1 - lx0;
                    if (dx == 0)
                        r = ly0;
                    else
                        r = ly0 + ((ly1 - ly0) * (lq - lx0)) / dx;
                    res.interpolated_y = fx_exp2(r);
                    res.out_of_range   = 1'b0;
                end
                expected_results = {expected_results, res};
            end
            default:
            begin
            end
        endcase
    endfunction

    // keep valid high across back-to-back transactions
    task automatic send_item(logic [1:0] op, logic [31:0] xv, logic [31:0] yv);
        lli_in_t it;
        int      gap;
        it.operation = op;
        it.x_value   = xv;
        it.y_value   = yv;
        gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        interp_model_step(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        int w;
        w = $urandom_range(1, 32);
        if ($urandom_range(0, 30) == 0)
            return 32'd0;
        return $urandom & ((w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1));
    endfunction

    task automatic test_directed();
        send_item(OP_QUERY, 32'h0001_0000, 32'd0);            // empty table
        send_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // ignored opcode
        send_item(OP_APPEND, 32'd0, 32'd0);                   // zeros as one LSB
        send_item(OP_APPEND, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(OP_APPEND, 32'h0001_0000, 32'h0000_0001);
        send_item(OP_APPEND, 32'h0001_0001, 32'h8000_0000);   // near-equal logs
        send_item(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 32'h0000_0001, 32'd0);
        send_item(OP_QUERY, 32'h0000_8000, 32'd0);
        send_item(OP_QUERY, 32'h0001_0000, 32'd0);
        send_item(OP_QUERY, 32'h0100_0000, 32'd0);
        send_item(OP_QUERY, 32'hFFFF_FFFE, 32'd0);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0);             // at the last point
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 32'h0000_0002, 32'd0);
        // steep ramp up to the top of the output range
        send_item(OP_APPEND, 32'h0001_0000, 32'h0001_0000);
        send_item(OP_APPEND, 32'h0002_0000, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 32'h0001_FFFF, 32'd0);
        send_item(OP_APPEND, 32'h0000_1000, 32'h5555_5555);   // out of order
        send_item(OP_QUERY, 32'h0000_0800, 32'd0);
        send_item(OP_QUERY, 32'h0001_8000, 32'd0);
        drain();
    endtask

    task automatic test_full_table();
        send_item(OP_CLEAR, 32'd1, 32'd1);
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
            send_item(OP_APPEND, 32'h0000_1000 + i * 32'h0010_0000, rand_value() | 32'd1);
        send_item(OP_QUERY, 32'hFFF0_0000, 32'd0);
        send_item(OP_QUERY, 32'h0800_0000, 32'd0);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
        drain();
    endtask

    // mostly clean ascending tables with queries inside them, some noise
    task automatic run_random_items(int n_items);
        logic [31:0] xs[$];
        logic [31:0] v;
        int          sent;
        int          k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                xs.delete();
                k = $urandom_range(2, 10);
                for (int i = 0; i < k; i++)
                    xs = {xs, rand_value()};
                xs.sort();
                send_item(OP_CLEAR, $urandom, $urandom);
                foreach (xs[i])
                    send_item(OP_APPEND, xs[i], rand_value());
                sent += k + 1;
                k = $urandom_range(2, 8);
                for (int i = 0; i < k; i++)
                begin
                    v = xs[$urandom_range(0, xs.size() - 1)];
                    if ($urandom_range(0, 3) != 0)
                        v = v + $urandom_range(0, 32'h7FFF_FFFF) % (v / 2 + 1);
                    else if ($urandom_range(0, 1) == 1)
                        v = rand_value();
                    send_item(OP_QUERY, v, $urandom);
                end
                sent += k;
            end
            else
            begin
                send_item(2'($urandom_range(0, 3)), rand_value(), rand_value());
                sent++;
            end
        end
    endtask

    task automatic test_random();
        idle_max = 12;
        run_random_items(1300);
        drain();
    endtask

    task automatic test_no_idle();
        idle_max = 0;
        run_random_items(150);
        drain();
        idle_max = 12;
    endtask

    task automatic test_output_stall();
        hold_off_cycles = 400;
        idle_max = 0;
        send_item(OP_CLEAR, 32'd5, 32'd5);
        send_item(OP_APPEND, 32'h0000_0100, 32'h0040_0000);
        send_item(OP_APPEND, 32'h0100_0000, 32'h0000_0010);
        for (int i = 0; i < 20; i++)
            send_item(OP_QUERY, $urandom_range(32'h100, 32'h0100_0000), $urandom);
        idle_max = 12;
        drain();
    endtask

    // result receiver with random back-pressure
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0 && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
            end
            gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid && (hold_off_cycles == 0 || hold_done));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result y=%h oor=%b", $time,
                         out_item.interpolated_y, out_item.out_of_range);
                mismatches++;
            end
            else
            begin
                if (out_item.interpolated_y !== expected_results[0].interpolated_y)
                begin
                    $display("%0t: interpolated_y expected %h actual %h", $time,
                             expected_results[0].interpolated_y, out_item.interpolated_y);
                    mismatches++;
                end
                if (out_item.out_of_range !== expected_results[0].out_of_range)
                begin
                    $display("%0t: out_of_range expected %b actual %b", $time,
                             expected_results[0].out_of_range, out_item.out_of_range);
                    mismatches++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[log_log_table_interpolator_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_item         = '0;
        tbl_count       = 0;
        idle_max        = 12;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_output_stall();
        test_no_idle();
        test_random();
        if (mismatches == 0)
            $display("[log_log_table_interpolator_unit] OK");
        else
            $display("[log_log_table_interpolator_unit] ERROR");
        $finish;
    end

endmodule
